FILE: rtl/core/pdsc_pkg.sv
// Shared types and constants for the packet deframer with sum check.
`default_nettype none
package pdsc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_SRC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_DST = 1'b1;

  // Result kinds
  localparam logic KIND_DATA      = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HDR2 = 4'd1,
    PH_SRC  = 4'd2,
    PH_DST  = 4'd3,
    PH_CTRL = 4'd4,
    PH_FUNC = 4'd5,
    PH_LEN  = 4'd6,
    PH_DATA = 4'd7,
    PH_CKH  = 4'd8,
    PH_CKL  = 4'd9
  } phase_t;

  typedef struct packed {
    logic              out_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] source_address;
    logic [BYTE_W-1:0] destination_address;
    logic [BYTE_W-1:0] control_code;
    logic [BYTE_W-1:0] function_code;
    logic [BYTE_W-1:0] payload_length;
    logic              checksum_ok;
    logic              address_match;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/packet_deframer_sum_check.sv
// Top level: byte-serial packet deframer with 16-bit sum check.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid / in_ready    | rx_byte, frame_start
//   out     | output    | out_valid / out_ready  | out_kind, data_byte, header fields,
//           |           |                        | checksum_ok, address_match
//   cfg     | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_ready is high; parsing and the sum
// update finish in the accept cycle and any result lands on the next edge in
// the output register or, while that is held, in the skid register, which keeps
// the input open for one more result; in_ready drops only when it is full.
// Synchronous reset clears the parser, the handshake state and the config.
`default_nettype none
module packet_deframer_sum_check import pdsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  input  wire logic                  frame_start,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [BYTE_W-1:0]          data_byte,
  output logic [BYTE_W-1:0]          source_address,
  output logic [BYTE_W-1:0]          destination_address,
  output logic [BYTE_W-1:0]          control_code,
  output logic [BYTE_W-1:0]          function_code,
  output logic [BYTE_W-1:0]          payload_length,
  output logic                       checksum_ok,
  output logic                       address_match,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [BYTE_W-1:0] exp_src;
  logic [BYTE_W-1:0] exp_dst;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] data_remaining, data_remaining_next;
  logic [SUM_W-1:0]  running_sum, running_sum_next;
  logic [BYTE_W-1:0] held_source, held_source_next;
  logic [BYTE_W-1:0] held_destination, held_destination_next;
  logic [BYTE_W-1:0] held_control, held_control_next;
  logic [BYTE_W-1:0] held_function, held_function_next;
  logic [BYTE_W-1:0] held_length, held_length_next;
  logic [BYTE_W-1:0] ck_high, ck_high_next;

  logic              accept;
  logic              res_valid;
  result_t           res;
  result_t           out_reg;
  result_t           skid_reg;
  logic              skid_valid;
  logic              pop;
  logic [SUM_W-1:0]  sum_plus;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;
  assign sum_plus = running_sum + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_src <= '0;
      exp_dst <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXP_SRC: exp_src <= cfg_wdata;
        CFG_EXP_DST: exp_dst <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser next state and result
  always_comb begin
    phase_next            = phase;
    data_remaining_next   = data_remaining;
    running_sum_next      = running_sum;
    held_source_next      = held_source;
    held_destination_next = held_destination;
    held_control_next     = held_control;
    held_function_next    = held_function;
    held_length_next      = held_length;
    ck_high_next          = ck_high;
    res_valid             = 1'b0;
    res                   = '0;

    if (accept) begin
      if (frame_start) begin
        running_sum_next    = {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
        data_remaining_next = '0;
        phase_next          = PH_HDR2;
      end else begin
        case (phase)
          PH_IDLE: ;
          PH_HDR2: begin
            running_sum_next = sum_plus;
            phase_next       = PH_SRC;
          end
          PH_SRC: begin
            running_sum_next = sum_plus;
            held_source_next = rx_byte;
            phase_next       = PH_DST;
          end
          PH_DST: begin
            running_sum_next      = sum_plus;
            held_destination_next = rx_byte;
            phase_next            = PH_CTRL;
          end
          PH_CTRL: begin
            running_sum_next  = sum_plus;
            held_control_next = rx_byte;
            phase_next        = PH_FUNC;
          end
          PH_FUNC: begin
            running_sum_next   = sum_plus;
            held_function_next = rx_byte;
            phase_next         = PH_LEN;
          end
          PH_LEN: begin
            running_sum_next    = sum_plus;
            held_length_next    = rx_byte;
            data_remaining_next = rx_byte;
            phase_next          = (rx_byte == '0) ? PH_CKH : PH_DATA;
          end
          PH_DATA: begin
            running_sum_next    = sum_plus;
            data_remaining_next = data_remaining - 1'b1;
            // last byte when the count was one (zero wraps to 255 more)
            if (data_remaining_next == '0) phase_next = PH_CKH;
            res_valid           = 1'b1;
            res.out_kind        = KIND_DATA;
            res.data_byte       = rx_byte;
          end
          PH_CKH: begin
            ck_high_next = rx_byte;
            phase_next   = PH_CKL;
          end
          PH_CKL: begin
            res_valid               = 1'b1;
            res.out_kind            = KIND_FRAME_END;
            res.source_address      = held_source;
            res.destination_address = held_destination;
            res.control_code        = held_control;
            res.function_code       = held_function;
            res.payload_length      = held_length;
            res.checksum_ok         = ({ck_high, rx_byte} == running_sum);
            res.address_match       = (held_source == exp_src) &&
                                      (held_destination == exp_dst);
            phase_next              = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      data_remaining   <= '0;
      running_sum      <= '0;
      held_source      <= '0;
      held_destination <= '0;
      held_control     <= '0;
      held_function    <= '0;
      held_length      <= '0;
      ck_high          <= '0;
    end else begin
      phase            <= phase_next;
      data_remaining   <= data_remaining_next;
      running_sum      <= running_sum_next;
      held_source      <= held_source_next;
      held_destination <= held_destination_next;
      held_control     <= held_control_next;
      held_function    <= held_function_next;
      held_length      <= held_length_next;
      ck_high          <= ck_high_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_reg <= skid_reg;
    end else if (!out_valid || pop) begin
      out_reg <= res;
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  assign out_kind            = out_reg.out_kind;
  assign data_byte           = out_reg.data_byte;
  assign source_address      = out_reg.source_address;
  assign destination_address = out_reg.destination_address;
  assign control_code        = out_reg.control_code;
  assign function_code       = out_reg.function_code;
  assign payload_length      = out_reg.payload_length;
  assign checksum_ok         = out_reg.checksum_ok;
  assign address_match       = out_reg.address_match;

endmodule
`default_nettype wire
